// ===== rtl/jcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcd_pkg
// Shared types and constants for the joystick dead-zone calibration block.
// ----------------------------------------------------------------------------
package jcd_pkg;

    // Axis sample width actually used (low bits of the 16-bit input fields)
    localparam int AXIS_BITS    = 16;
    localparam int ZONE_DIVISOR = 10;

    // Field widths on the stream ports
    localparam int AXIS_FIELD_BITS   = 16;
    localparam int BUTTON_BITS       = 8;
    localparam int IN_PAYLOAD_BITS   = 2 * AXIS_FIELD_BITS + BUTTON_BITS + 2;
    localparam int IN_TDATA_BITS     = ((IN_PAYLOAD_BITS + 7) / 8) * 8;
    localparam int PHASE_BITS        = 3;
    localparam int OUT_PAYLOAD_BITS  = 4 + PHASE_BITS + 1;
    localparam int OUT_TDATA_BITS    = ((OUT_PAYLOAD_BITS + 7) / 8) * 8;

    // Button 1 is active low at this bit of the switch byte
    localparam int BUTTON1_BIT = 4;

    // Constant division by reciprocal multiply, exact for SPAN_BITS-wide inputs
    localparam int SPAN_BITS  = AXIS_BITS + 1;
    localparam int DIV_SHIFT  = SPAN_BITS + $clog2(ZONE_DIVISOR);
    localparam int RECIP_BITS = SPAN_BITS + 1;
    localparam int PROD_BITS  = DIV_SHIFT + AXIS_BITS;
    localparam logic [RECIP_BITS-1:0] DIV_RECIP =
        RECIP_BITS'(((longint'(1) << DIV_SHIFT) + ZONE_DIVISOR - 1) / ZONE_DIVISOR);
    localparam logic [SPAN_BITS-1:0] ROUND_UP = SPAN_BITS'(ZONE_DIVISOR - 1);
    localparam logic [AXIS_BITS-1:0] AXIS_MAX = '1;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_MINMAX   = 3'd0,
        PH_RELEASE1 = 3'd1,
        PH_CENTRE   = 3'd2,
        PH_RELEASE2 = 3'd3,
        PH_FINAL    = 3'd4,
        PH_RELEASE3 = 3'd5
    } phase_t;

    // floor(value / ZONE_DIVISOR)
    function automatic logic [AXIS_BITS-1:0] div_zone(input logic [SPAN_BITS-1:0] value);
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(value) * PROD_BITS'(DIV_RECIP);
        return prod[DIV_SHIFT +: AXIS_BITS];
    endfunction

endpackage

// ===== rtl/joystick_calibrate_deadzone_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_calibrate_deadzone_top
// Per-sample joystick calibration: min/max tracking, press/release phases,
// centre capture with dead zones, and left/right/up/down flags.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Handshake         | Payload
// ---------+-----+-------------------+------------------------------------------
// s_*      | in  | s_tvalid/s_tready | axis_x, axis_y, button_byte, restart, quit
// m_*      | out | m_tvalid/m_tready | dir flags, calib_phase, calib_done
//
// One item per cycle sustained while m_tready stays high. An accepted item
// waits in the input register and moves into the result register, which
// drives m_tvalid, once that register can advance (no m_tready stall).
// Per-item logic is a compare/update of the calibration state plus compares
// against the registered dead zones.
// The span/10 quotients come from a registered reciprocal multiply running off
// the min/max registers; centre capture is always at least two items after
// the last min/max change, so the quotients are settled by then.
// rst_n (async, active low) clears both stage valids and all calibration state.
// A stall on m_tready holds the result; the input register keeps taking items
// only while it can drain, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module joystick_calibrate_deadzone_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] axis_x, [31:16] axis_y, [39:32] button_byte,
    // [40] restart_request, [41] quit_request, [47:42] zero
    input  logic [jcd_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] dir_left, [1] dir_right, [2] dir_up, [3] dir_down,
    // [6:4] calib_phase, [7] calib_done
    output logic [jcd_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);

    localparam int AB = jcd_pkg::AXIS_BITS;
    localparam int FB = jcd_pkg::AXIS_FIELD_BITS;
    localparam int BB = jcd_pkg::BUTTON_BITS;

    // ---------------- input register ----------------
    logic                in_valid_reg;
    logic [AB-1:0]       in_x_reg;
    logic [AB-1:0]       in_y_reg;
    logic [BB-1:0]       in_btn_reg;
    logic                in_restart_reg;
    logic                in_quit_reg;

    // ---------------- result register ----------------
    logic                                  out_valid_reg;
    logic [jcd_pkg::OUT_TDATA_BITS-1:0]    out_data_reg;
    logic [jcd_pkg::OUT_TDATA_BITS-1:0]    out_data_next;

    // ---------------- calibration state ----------------
    jcd_pkg::phase_t     phase_reg, phase_next;
    logic                finished_reg, finished_next;
    logic                seeded_reg, seeded_next;
    logic [AB-1:0]       min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic [AB-1:0]       min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic [AB-1:0]       zone_x_low_reg, zone_x_low_next, zone_x_high_reg, zone_x_high_next;
    logic [AB-1:0]       zone_y_low_reg, zone_y_low_next, zone_y_high_reg, zone_y_high_next;

    // span quotients: up = floor(span/D), down = ceil(span/D)
    logic [AB-1:0]       up_x_reg, down_x_reg, up_y_reg, down_y_reg;
    logic [AB-1:0]       span_x, span_y;

    logic                advance;
    logic                fire;
    logic                pressed;
    logic                capture;
    jcd_pkg::phase_t     phase_eff;
    logic [AB-1:0]       base_min_x, base_max_x, base_min_y, base_max_y;
    logic [AB:0]         sum_x, sum_y;

    // ---------------- handshake ----------------
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_x_reg       <= '0;
            in_y_reg       <= '0;
            in_btn_reg     <= '0;
            in_restart_reg <= 1'b0;
            in_quit_reg    <= 1'b0;
        end
        else if (s_tready && s_tvalid)
        begin
            in_x_reg       <= s_tdata[AB-1:0];
            in_y_reg       <= s_tdata[FB +: AB];
            in_btn_reg     <= s_tdata[2*FB +: BB];
            in_restart_reg <= s_tdata[2*FB + BB];
            in_quit_reg    <= s_tdata[2*FB + BB + 1];
        end
    end

    // ---------------- dead-zone quotients ----------------
    assign span_x = (max_x_reg >= min_x_reg) ? (max_x_reg - min_x_reg) : '0;
    assign span_y = (max_y_reg >= min_y_reg) ? (max_y_reg - min_y_reg) : '0;

    always_ff @(posedge clk)
    begin
        up_x_reg   <= jcd_pkg::div_zone(jcd_pkg::SPAN_BITS'(span_x));
        up_y_reg   <= jcd_pkg::div_zone(jcd_pkg::SPAN_BITS'(span_y));
        down_x_reg <= jcd_pkg::div_zone(jcd_pkg::SPAN_BITS'(span_x) + jcd_pkg::ROUND_UP);
        down_y_reg <= jcd_pkg::div_zone(jcd_pkg::SPAN_BITS'(span_y) + jcd_pkg::ROUND_UP);
    end

    // ---------------- next state ----------------
    assign pressed = !in_btn_reg[jcd_pkg::BUTTON1_BIT];
    assign sum_x   = {1'b0, in_x_reg} + {1'b0, up_x_reg};
    assign sum_y   = {1'b0, in_y_reg} + {1'b0, up_y_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        finished_next    = finished_reg;
        seeded_next      = seeded_reg;
        min_x_next       = min_x_reg;
        max_x_next       = max_x_reg;
        min_y_next       = min_y_reg;
        max_y_next       = max_y_reg;
        zone_x_low_next  = zone_x_low_reg;
        zone_x_high_next = zone_x_high_reg;
        zone_y_low_next  = zone_y_low_reg;
        zone_y_high_next = zone_y_high_reg;
        capture          = 1'b0;

        // first sample seeds the trackers
        base_min_x = seeded_reg ? min_x_reg : in_x_reg;
        base_max_x = seeded_reg ? max_x_reg : in_x_reg;
        base_min_y = seeded_reg ? min_y_reg : in_y_reg;
        base_max_y = seeded_reg ? max_y_reg : in_y_reg;
        phase_eff  = in_restart_reg ? jcd_pkg::PH_MINMAX : phase_reg;

        if (!finished_reg)
        begin
            seeded_next = 1'b1;
            min_x_next  = base_min_x;
            max_x_next  = base_max_x;
            min_y_next  = base_min_y;
            max_y_next  = base_max_y;
            phase_next  = phase_eff;

            unique case (phase_eff)
                jcd_pkg::PH_MINMAX:
                begin
                    if (in_x_reg > base_max_x) max_x_next = in_x_reg;
                    if (in_y_reg > base_max_y) max_y_next = in_y_reg;
                    if (in_x_reg < base_min_x) min_x_next = in_x_reg;
                    if (in_y_reg < base_min_y) min_y_next = in_y_reg;
                    if (pressed) phase_next = jcd_pkg::PH_RELEASE1;
                end
                jcd_pkg::PH_RELEASE1:
                begin
                    if (!pressed) phase_next = jcd_pkg::PH_CENTRE;
                end
                jcd_pkg::PH_CENTRE:
                begin
                    if (pressed)
                    begin
                        phase_next = jcd_pkg::PH_RELEASE2;
                        capture    = 1'b1;
                        zone_x_low_next  = (in_x_reg >= down_x_reg) ? in_x_reg - down_x_reg : '0;
                        zone_y_low_next  = (in_y_reg >= down_y_reg) ? in_y_reg - down_y_reg : '0;
                        zone_x_high_next = sum_x[AB] ? jcd_pkg::AXIS_MAX : sum_x[AB-1:0];
                        zone_y_high_next = sum_y[AB] ? jcd_pkg::AXIS_MAX : sum_y[AB-1:0];
                    end
                end
                jcd_pkg::PH_RELEASE2:
                begin
                    if (!pressed) phase_next = jcd_pkg::PH_FINAL;
                end
                jcd_pkg::PH_FINAL:
                begin
                    if (pressed) phase_next = jcd_pkg::PH_RELEASE3;
                end
                jcd_pkg::PH_RELEASE3:
                begin
                    if (!pressed) finished_next = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (in_quit_reg) finished_next = 1'b1;
        end
    end

    // ---------------- result ----------------
    // On a capture the new zones bracket the sample itself, so all flags are 0.
    always_comb
    begin
        out_data_next = '0;
        if (!capture)
        begin
            out_data_next[0] = in_x_reg < zone_x_low_reg;
            out_data_next[1] = in_x_reg > zone_x_high_reg;
            out_data_next[2] = in_y_reg < zone_y_low_reg;
            out_data_next[3] = in_y_reg > zone_y_high_reg;
        end
        out_data_next[4 +: jcd_pkg::PHASE_BITS] = phase_next;
        out_data_next[4 + jcd_pkg::PHASE_BITS]  = finished_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            phase_reg       <= jcd_pkg::PH_MINMAX;
            finished_reg    <= 1'b0;
            seeded_reg      <= 1'b0;
            min_x_reg       <= '0;
            max_x_reg       <= '0;
            min_y_reg       <= '0;
            max_y_reg       <= '0;
            zone_x_low_reg  <= '0;
            zone_x_high_reg <= '0;
            zone_y_low_reg  <= '0;
            zone_y_high_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                phase_reg       <= phase_next;
                finished_reg    <= finished_next;
                seeded_reg      <= seeded_next;
                min_x_reg       <= min_x_next;
                max_x_reg       <= max_x_next;
                min_y_reg       <= min_y_next;
                max_y_reg       <= max_y_next;
                zone_x_low_reg  <= zone_x_low_next;
                zone_x_high_reg <= zone_x_high_next;
                zone_y_low_reg  <= zone_y_low_next;
                zone_y_high_reg <= zone_y_high_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ---------------- assertions ----------------
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("calibration done flag dropped");

    a_phase_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> phase_reg == $past(phase_reg))
        else $error("phase changed after calibration done");

    a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |-> (min_x_reg <= max_x_reg) && (min_y_reg <= max_y_reg))
        else $error("min/max trackers out of order");

    a_zone_order: assert property (@(posedge clk) disable iff (!rst_n)
        (zone_x_low_reg <= zone_x_high_reg) && (zone_y_low_reg <= zone_y_high_reg))
        else $error("dead zone bounds out of order");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("held item lost during output stall");

endmodule

// ===== test/tb_joystick_calibrate_deadzone_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_calibrate_deadzone_top
// Self-checking bench for the joystick dead-zone calibration block. A scripted
// walk through the calibration phases comes first, then phase-aware random
// samples. Each accepted sample goes through a local calibration model, and
// every result item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_joystick_calibrate_deadzone_top;

    localparam int  RANDOM_ITEMS = 1050;
    localparam int  DRAIN_AT     = 550;      // sender holds off here until drained
    localparam int  FROZEN_ITEMS = 20;       // samples sent after calibration is done
    localparam longint CYCLE_LIMIT = 400000;
    localparam int  MAX_REPORTS  = 10;

    // One input item, packed exactly as s_tdata (x in the low bits)
    typedef struct packed {
        logic                                quit;
        logic                                restart;
        logic [jcd_pkg::BUTTON_BITS-1:0]     buttons;
        logic [jcd_pkg::AXIS_FIELD_BITS-1:0] y;
        logic [jcd_pkg::AXIS_FIELD_BITS-1:0] x;
    } sample_t;

    localparam int SAMPLE_BITS = $bits(sample_t);

    // One result item, packed exactly as m_tdata
    typedef struct packed {
        logic                           done;
        logic [jcd_pkg::PHASE_BITS-1:0] phase;
        logic                           down;
        logic                           up;
        logic                           right;
        logic                           left;
    } calib_result_t;

    // Scripted row; flags are {down, up, right, left}, used only when known
    typedef struct packed {
        logic [15:0]     x;
        logic [15:0]     y;
        logic [7:0]      buttons;
        logic            restart;
        logic            quit;
        logic            known;
        logic [3:0]      flags;
        jcd_pkg::phase_t phase;
        logic            done;
    } script_row_t;

    // Bit 4 clear in the button byte means pressed (EF, 00, E0, C3 press).
    localparam int SCRIPT_LEN = 23;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // first sample seeds min/max; zones still zero
        '{16'h8000, 16'h8000, 8'hFF, 1'b0, 1'b0, 1'b1, 4'b1010, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h8000, 16'h8000, 8'hEF, 1'b0, 1'b0, 1'b1, 4'b1010, jcd_pkg::PH_RELEASE1, 1'b0},
        // held press does not advance
        '{16'h8000, 16'h8000, 8'hEF, 1'b0, 1'b0, 1'b1, 4'b1010, jcd_pkg::PH_RELEASE1, 1'b0},
        '{16'h8000, 16'h8000, 8'h10, 1'b0, 1'b0, 1'b1, 4'b1010, jcd_pkg::PH_CENTRE, 1'b0},
        '{16'h1234, 16'h4321, 8'hFF, 1'b0, 1'b0, 1'b1, 4'b1010, jcd_pkg::PH_CENTRE, 1'b0},
        // centre capture with zero span
        '{16'h8000, 16'h8000, 8'h00, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h7FFF, 16'h8001, 8'hFF, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h8001, 16'h7FFF, 8'hEF, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        // restart beats the final release; min/max kept and widened
        '{16'h8005, 16'h7FF6, 8'hFF, 1'b1, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        // restart together with a press
        '{16'h7FFB, 16'h800A, 8'hEF, 1'b1, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h0000, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        // centre at the corners: low x saturates at 0, high y at full scale
        '{16'h0000, 16'hFFFF, 8'hEF, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'hFFFF, 16'h0000, 8'hFF, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h0000, 16'h0000, 8'hEF, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h8000, 16'h8000, 8'h7F, 1'b1, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h8000, 16'h8000, 8'hE0, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h8000, 16'h8000, 8'h1F, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        // opposite corner: high x saturates, low y saturates at 0
        '{16'hFFFF, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h7FFF, 16'h7FFF, 8'hFF, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'hFFFE, 16'h0003, 8'hFF, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h8000, 16'h8000, 8'hEF, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h8000, 16'h8000, 8'hC3, 1'b0, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0},
        '{16'h8000, 16'h8000, 8'hFF, 1'b1, 1'b0, 1'b0, 4'b0000, jcd_pkg::PH_MINMAX, 1'b0}
    };

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [jcd_pkg::IN_TDATA_BITS-1:0]  s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [jcd_pkg::OUT_TDATA_BITS-1:0] m_tdata;

    // Shadow calibration state
    jcd_pkg::phase_t               cal_phase;
    logic                          cal_done;
    logic                          cal_seeded;
    logic [jcd_pkg::AXIS_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [jcd_pkg::AXIS_BITS-1:0] zone_xl, zone_xh, zone_yl, zone_yh;

    calib_result_t awaited_results [$];
    int            mismatch_count;
    longint        cycle_count;
    bit            steady;          // both sides stop idling while set
    calib_result_t got_res;
    calib_result_t want_res;

    joystick_calibrate_deadzone_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Dead-zone bounds for one axis: centre - ceil(span/D), centre + floor(span/D)
    task automatic place_zone(input logic [jcd_pkg::AXIS_BITS-1:0] centre,
                              input logic [jcd_pkg::AXIS_BITS-1:0] lo,
                              input logic [jcd_pkg::AXIS_BITS-1:0] hi,
                              output logic [jcd_pkg::AXIS_BITS-1:0] zlo,
                              output logic [jcd_pkg::AXIS_BITS-1:0] zhi);
        logic [jcd_pkg::AXIS_BITS:0] span;
        logic [jcd_pkg::AXIS_BITS:0] below;
        logic [jcd_pkg::AXIS_BITS:0] above;
        logic [jcd_pkg::AXIS_BITS:0] top;
        span  = (hi >= lo) ? ({1'b0, hi} - {1'b0, lo}) : '0;
        below = (jcd_pkg::AXIS_BITS+1)'((span + jcd_pkg::ZONE_DIVISOR - 1)
                                        / jcd_pkg::ZONE_DIVISOR);
        above = (jcd_pkg::AXIS_BITS+1)'(span / jcd_pkg::ZONE_DIVISOR);
        top   = {1'b0, centre} + above;
        zlo   = ({1'b0, centre} >= below) ?
                jcd_pkg::AXIS_BITS'({1'b0, centre} - below) : '0;
        zhi   = top[jcd_pkg::AXIS_BITS] ? '1 : top[jcd_pkg::AXIS_BITS-1:0];
    endtask

    // Advance the shadow calibration by one sample and form its result
    task automatic calibrate_sample(input sample_t smp, output calib_result_t res);
        logic [jcd_pkg::AXIS_BITS-1:0] x;
        logic [jcd_pkg::AXIS_BITS-1:0] y;
        logic                          pressed;
        x       = smp.x[jcd_pkg::AXIS_BITS-1:0];
        y       = smp.y[jcd_pkg::AXIS_BITS-1:0];
        pressed = !smp.buttons[jcd_pkg::BUTTON1_BIT];
        if (!cal_done)
        begin
            if (!cal_seeded)
            begin
                lo_x = x;
                hi_x = x;
                lo_y = y;
                hi_y = y;
                cal_seeded = 1'b1;
            end
            if (smp.restart)
                cal_phase = jcd_pkg::PH_MINMAX;
            case (cal_phase)
                jcd_pkg::PH_MINMAX:
                begin
                    if (x > hi_x) hi_x = x;
                    if (y > hi_y) hi_y = y;
                    if (x < lo_x) lo_x = x;
                    if (y < lo_y) lo_y = y;
                    if (pressed) cal_phase = jcd_pkg::PH_RELEASE1;
                end
                jcd_pkg::PH_RELEASE1: if (!pressed) cal_phase = jcd_pkg::PH_CENTRE;
                jcd_pkg::PH_CENTRE:
                begin
                    if (pressed)
                    begin
                        cal_phase = jcd_pkg::PH_RELEASE2;
                        place_zone(x, lo_x, hi_x, zone_xl, zone_xh);
                        place_zone(y, lo_y, hi_y, zone_yl, zone_yh);
                    end
                end
                jcd_pkg::PH_RELEASE2: if (!pressed) cal_phase = jcd_pkg::PH_FINAL;
                jcd_pkg::PH_FINAL:    if (pressed) cal_phase = jcd_pkg::PH_RELEASE3;
                jcd_pkg::PH_RELEASE3: if (!pressed) cal_done = 1'b1;
                default: ;
            endcase
            if (smp.quit)
                cal_done = 1'b1;
        end
        res.left  = (x < zone_xl);
        res.right = (x > zone_xh);
        res.up    = (y < zone_yl);
        res.down  = (y > zone_yh);
        res.phase = cal_phase;
        res.done  = cal_done;
    endtask

    // Axis value: a slowly widening window around mid-scale while min/max are
    // tracked (so spans grow over the run), otherwise extremes, noise, or a
    // value within one of a dead-zone bound.
    function automatic logic [15:0] pick_axis(input logic tracking, input int k,
                                              input logic [15:0] zlo,
                                              input logic [15:0] zhi);
        int half;
        int lo;
        int hi;
        if (tracking)
        begin
            half = 16 + 32 * k;
            lo   = 'h8000 - half;
            hi   = 'h7FFF + half;
            if (lo < 0) lo = 0;
            if (hi > 'hFFFF) hi = 'hFFFF;
            return 16'($urandom_range(lo, hi));
        end
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1:       return 16'($urandom);
            2:       return 16'(zlo + $urandom_range(0, 2) - 1);
            default: return 16'(zhi + $urandom_range(0, 2) - 1);
        endcase
    endfunction

    // Mostly well-formed press/release steps for the current phase. A release
    // in the last phase would end calibration for good, so it becomes a restart.
    task automatic make_sample(input int k, input logic allow_restart, output sample_t smp);
        logic            restart;
        logic            advance;
        logic            pressed;
        jcd_pkg::phase_t eff;
        restart = allow_restart && ($urandom_range(0, 24) == 0);
        eff     = restart ? jcd_pkg::PH_MINMAX : cal_phase;
        if (eff == jcd_pkg::PH_MINMAX)
            advance = ($urandom_range(0, 3) == 0);
        else
            advance = ($urandom_range(0, 3) != 0);
        if (eff == jcd_pkg::PH_MINMAX || eff == jcd_pkg::PH_CENTRE ||
            eff == jcd_pkg::PH_FINAL)
            pressed = advance;
        else
            pressed = !advance;
        if (eff == jcd_pkg::PH_RELEASE3 && !pressed)
        begin
            restart = 1'b1;
            eff     = jcd_pkg::PH_MINMAX;
        end
        smp.quit    = 1'b0;
        smp.restart = restart;
        smp.buttons = 8'($urandom_range(0, 255));
        smp.buttons[jcd_pkg::BUTTON1_BIT] = !pressed;
        smp.x = pick_axis(eff == jcd_pkg::PH_MINMAX, k, zone_xl, zone_xh);
        smp.y = pick_axis(eff == jcd_pkg::PH_MINMAX, k, zone_yl, zone_yh);
    endtask

    // Offer one item after a random gap; predict it once accepted
    task automatic send_sample(input sample_t smp, input logic known,
                               input calib_result_t typed_res);
        int            gap;
        calib_result_t res;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= jcd_pkg::IN_TDATA_BITS'(smp);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        calibrate_sample(smp, res);
        awaited_results.push_back(known ? typed_res : res);
    endtask

    task automatic wait_drained();
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        sample_t smp;
        int      k;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        steady     = 1'b0;
        cal_phase  = jcd_pkg::PH_MINMAX;
        cal_done   = 1'b0;
        cal_seeded = 1'b0;
        lo_x = '0; hi_x = '0; lo_y = '0; hi_y = '0;
        zone_xl = '0; zone_xh = '0; zone_yl = '0; zone_yh = '0;
        mismatch_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Scripted walk through the phases
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            smp.x       = SCRIPT[i].x;
            smp.y       = SCRIPT[i].y;
            smp.buttons = SCRIPT[i].buttons;
            smp.restart = SCRIPT[i].restart;
            smp.quit    = SCRIPT[i].quit;
            send_sample(smp, SCRIPT[i].known,
                        {SCRIPT[i].done, SCRIPT[i].phase, SCRIPT[i].flags});
        end

        // Random calibration cycles, restarted over and over
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            steady = ((k % 128) < 20);
            if (k == DRAIN_AT)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                wait_drained();
            end
            make_sample(k, 1'b1, smp);
            send_sample(smp, 1'b0, '0);
        end

        // Walk up to the last phase, then end calibration. Done sticks until
        // reset, so the seed picks the ending: a plain final release, or
        // restart and quit in the same item.
        steady = 1'b0;
        while (cal_phase != jcd_pkg::PH_RELEASE3)
        begin
            make_sample(k, 1'b0, smp);
            send_sample(smp, 1'b0, '0);
        end
        make_sample(k, 1'b0, smp);
        if ($urandom_range(0, 1))
        begin
            smp.restart = 1'b0;
            smp.quit    = 1'b0;
            smp.buttons[jcd_pkg::BUTTON1_BIT] = 1'b1;
        end
        else
        begin
            smp.restart = 1'b1;
            smp.quit    = 1'b1;
        end
        send_sample(smp, 1'b0, '0);

        // Frozen: restart and quit are ignored, flags still follow the zones
        for (int i = 0; i < FROZEN_ITEMS; i++)
        begin
            smp = '0;
            if (i > 1 || $urandom_range(0, 1))
                smp = sample_t'(SAMPLE_BITS'({$urandom, $urandom}));
            send_sample(smp, 1'b0, '0);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side back-pressure
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready)) @(posedge clk);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = m_tdata;
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result item %h at cycle %0d", got_res, cycle_count);
            end
            else
            begin
                want_res = awaited_results.pop_front();
                if (got_res.left  !== want_res.left  || got_res.right !== want_res.right ||
                    got_res.up    !== want_res.up    || got_res.down  !== want_res.down  ||
                    got_res.phase !== want_res.phase || got_res.done  !== want_res.done)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch at cycle %0d: exp L%b R%b U%b D%b ph%0d dn%b,",
                                  " got L%b R%b U%b D%b ph%0d dn%b"},
                                 cycle_count,
                                 want_res.left, want_res.right, want_res.up, want_res.down,
                                 want_res.phase, want_res.done,
                                 got_res.left, got_res.right, got_res.up, got_res.down,
                                 got_res.phase, got_res.done);
                end
            end
        end
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

// ===== joystick_calibrate_deadzone_top.f =====
rtl/jcd_pkg.sv
rtl/joystick_calibrate_deadzone_top.sv
test/tb_joystick_calibrate_deadzone_top.sv
